// ===== rtl/tcgr_pkg.sv =====
package tcgr_pkg;

  // fixed geometry and field widths
  localparam int GlyphWidth = 8;
  localparam int PxW        = 13;
  localparam int FontAw     = 12;
  localparam int ColorW     = 16;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int InDataW    = 48;
  localparam int OutDataW   = 168;

  // special character codes
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] CharCr = 8'h0D;

  // input word kinds
  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_CURSOR = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FONT_HEIGHT = 3'd0,
    CFG_COL_GAP     = 3'd1,
    CFG_LINE_GAP    = 3'd2,
    CFG_FG_COLOR    = 3'd3,
    CFG_BG_COLOR    = 3'd4,
    CFG_TRANSPARENT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]        font_height;
    logic [3:0]        col_gap;
    logic [3:0]        line_gap;
    logic [ColorW-1:0] fg_color;
    logic [ColorW-1:0] bg_color;
    logic              transparent;
  } cfg_t;

  // one input word, unpacked
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        char_code;
    logic [FontAw-1:0] font_addr;
    logic [7:0]        font_byte;
    logic [7:0]        cursor_col;
    logic [7:0]        cursor_row;
  } item_t;

  // position data that travels with a glyph row read
  typedef struct packed {
    logic [PxW-1:0] px_x;
    logic [PxW-1:0] px_y;
    logic           last_row;
  } row_meta_t;

endpackage

// ===== rtl/tcgr_font_mem.sv =====
module tcgr_font_mem
  import tcgr_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [FontAw-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [FontAw-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  localparam int Depth = 1 << FontAw;

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  // glyph row store, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tcgr_ctrl.sv =====
module tcgr_ctrl
  import tcgr_pkg::*;
#(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int SCREEN_WIDTH   = 240
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  item_t             item_i,
  input  logic              space_i,
  output logic              mem_we_o,
  output logic [FontAw-1:0] mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [FontAw-1:0] mem_raddr_o,
  output logic              rd_valid_o,
  output row_meta_t         rd_meta_o
);

  localparam int RowW  = $clog2(MAX_GLYPH_ROWS + 1);
  localparam int WrapX = SCREEN_WIDTH + 1 - GlyphWidth;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XMUL,
    ST_WRAP,
    ST_YMUL,
    ST_ROWS
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        col_q, col_d;
  logic [7:0]        line_q, line_d;
  logic [7:0]        char_q, char_d;
  logic [RowW-1:0]   h_q, h_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [PxW-1:0]    xoff_q, xoff_d;
  logic [PxW-1:0]    yoff_q, yoff_d;
  logic [FontAw-1:0] base_q, base_d;
  logic              rd_v_q, rd_v_d;
  row_meta_t         meta_q, meta_d;
  logic              accept;
  logic              issue;
  logic              is_last;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign issue      = (state_q == ST_ROWS) && space_i;
  assign is_last    = (row_q + RowW'(1)) == h_q;

  // font loads write straight through at accept
  assign mem_we_o    = accept && (item_i.kind == KIND_LOAD);
  assign mem_waddr_o = item_i.font_addr;
  assign mem_wdata_o = item_i.font_byte;
  assign mem_re_o    = issue;
  assign mem_raddr_o = base_q + FontAw'(row_q);

  // sequencer: cursor, offsets and row reads
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    line_d  = line_q;
    char_d  = char_q;
    h_d     = h_q;
    row_d   = row_q;
    xoff_d  = xoff_q;
    yoff_d  = yoff_q;
    base_d  = base_q;
    rd_v_d  = 1'b0;
    meta_d  = meta_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            KIND_LOAD: ;
            KIND_CURSOR: begin
              col_d  = item_i.cursor_col;
              line_d = item_i.cursor_row;
            end
            KIND_PUT: begin
              if (item_i.char_code == CharLf) begin
                line_d = sat_inc(line_q);
                col_d  = 8'd0;
              end else if (item_i.char_code == CharCr) begin
                col_d = 8'd0;
              end else begin
                char_d  = item_i.char_code;
                state_d = ST_XMUL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_XMUL: begin
        xoff_d  = PxW'(col_q) * (PxW'(GlyphWidth) + PxW'(cfg_i.col_gap));
        h_d     = (cfg_i.font_height > 5'(MAX_GLYPH_ROWS)) ? RowW'(MAX_GLYPH_ROWS)
                                                            : RowW'(cfg_i.font_height);
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        if (xoff_q >= PxW'(WrapX)) begin
          xoff_d = '0;
          col_d  = 8'd0;
          line_d = sat_inc(line_q);
        end
        state_d = ST_YMUL;
      end
      ST_YMUL: begin
        yoff_d = PxW'(line_q) * (PxW'(h_q) + PxW'(cfg_i.line_gap));
        base_d = FontAw'({4'd0, char_q} * FontAw'(h_q));
        row_d  = '0;
        if (h_q == '0) begin
          col_d   = sat_inc(col_q);
          state_d = ST_IDLE;
        end else begin
          state_d = ST_ROWS;
        end
      end
      ST_ROWS: begin
        if (issue) begin
          rd_v_d          = 1'b1;
          meta_d.px_x     = xoff_q + PxW'(1);
          meta_d.px_y     = yoff_q + PxW'(row_q);
          meta_d.last_row = is_last;
          row_d           = row_q + RowW'(1);
          if (is_last) begin
            col_d   = sat_inc(col_q);
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= 8'd0;
      line_q  <= 8'd0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      line_q  <= line_d;
      rd_v_q  <= rd_v_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    h_q    <= h_d;
    row_q  <= row_d;
    xoff_q <= xoff_d;
    yoff_q <= yoff_d;
    base_q <= base_d;
    meta_q <= meta_d;
  end

  assign rd_valid_o = rd_v_q;
  assign rd_meta_o  = meta_q;

endmodule

// ===== rtl/tcgr_row_fmt.sv =====
module tcgr_row_fmt
  import tcgr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                push_i,
  input  logic [7:0]          bits_i,
  input  row_meta_t           meta_i,
  input  logic                inflight_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o
);

  typedef struct packed {
    logic [7:0] bits;
    row_meta_t  meta;
  } entry_t;

  entry_t     buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  logic [2:0] fill_next;
  entry_t     head;
  logic [7:0] mask;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);

  // a new read may start only if its word is sure to find a slot
  assign fill_next = 3'(cnt_q) + 3'(inflight_i) - 3'(pop);
  assign space_o   = (fill_next < 3'd2);

  // two-entry row buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= '{bits: bits_i, meta: meta_i};
    end
  end

  // expand the glyph row into colors and write mask
  assign head = buf_q[rptr_q];

  always_comb begin
    for (int k = 0; k < GlyphWidth; k++) begin
      mask[k] = cfg_i.transparent ? head.bits[GlyphWidth-1-k] : 1'b1;
    end
  end

  always_comb begin
    out_data_o                  = '0;
    out_data_o[PxW-1:0]         = head.meta.px_x;
    out_data_o[2*PxW-1:PxW]     = head.meta.px_y;
    for (int k = 0; k < GlyphWidth; k++) begin
      out_data_o[2*PxW+k*ColorW +: ColorW] =
        head.bits[GlyphWidth-1-k] ? cfg_i.fg_color : cfg_i.bg_color;
    end
    out_data_o[2*PxW+GlyphWidth*ColorW +: GlyphWidth] = mask;
  end

  assign out_last_o = head.meta.last_row;

endmodule

// ===== rtl/text_console_glyph_renderer.sv =====
// Text console glyph renderer: turns a stream of character words into pixel row
// writes for an 8-pixel-wide bitmap font, keeping a text cursor and a 4096 x 8
// font store in one synchronous RAM.
// Input channel (s_axis): tuser selects the kind of word: put character, load one
// font byte, or set the cursor. Loads and cursor moves give no output; newline and
// carriage return likewise move the cursor only.
// A printed character has the x offset, the line wrap and the y offset worked out
// in turn, then one font RAM read per glyph row, h being the clamped font height,
// one row per cycle through the RAM read port while the row buffer has space.
// Output channel (m_axis): one word per glyph row, tlast on the final row. The
// first row word goes valid once its RAM read has been written into the buffer.
// Rows pass a two-entry buffer; when the receiver stalls, reads stop once the
// buffer is committed and resume as it drains. A new input word is taken as
// soon as the last row read of the previous character has been issued.
// Configuration writes (cfg_we_i) take effect at once and belong to idle times.
// Reset clears the cursor and sets the register defaults; the font store keeps
// no reset value and must be loaded before characters are drawn.
module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int SCREEN_WIDTH   = 240
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // char_code, font_addr, font_byte, cursor_col, cursor_row, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  logic [1:0]          s_axis_tuser,
  // glyph row words
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // px_x, px_y, color0 .. color7, write_mask, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // last_row
  output logic                m_axis_tlast,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t              cfg_q;
  item_t             item;
  logic              mem_we, mem_re;
  logic [FontAw-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              rd_valid;
  row_meta_t         rd_meta;
  logic              space;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_height <= 5'd16;
      cfg_q.col_gap     <= 4'd1;
      cfg_q.line_gap    <= 4'd1;
      cfg_q.fg_color    <= 16'hFFFF;
      cfg_q.bg_color    <= 16'h0000;
      cfg_q.transparent <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FONT_HEIGHT: cfg_q.font_height <= cfg_wdata_i[4:0];
        CFG_COL_GAP:     cfg_q.col_gap     <= cfg_wdata_i[3:0];
        CFG_LINE_GAP:    cfg_q.line_gap    <= cfg_wdata_i[3:0];
        CFG_FG_COLOR:    cfg_q.fg_color    <= cfg_wdata_i;
        CFG_BG_COLOR:    cfg_q.bg_color    <= cfg_wdata_i;
        CFG_TRANSPARENT: cfg_q.transparent <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // unpack the input word
  assign item.kind       = s_axis_tuser;
  assign item.char_code  = s_axis_tdata[7:0];
  assign item.font_addr  = s_axis_tdata[19:8];
  assign item.font_byte  = s_axis_tdata[27:20];
  assign item.cursor_col = s_axis_tdata[35:28];
  assign item.cursor_row = s_axis_tdata[43:36];

  tcgr_ctrl #(
    .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS),
    .SCREEN_WIDTH  (SCREEN_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .item_i     (item),
    .space_i    (space),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .rd_valid_o (rd_valid),
    .rd_meta_o  (rd_meta)
  );

  tcgr_font_mem u_font_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  tcgr_row_fmt u_row_fmt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (rd_valid),
    .bits_i     (mem_rdata),
    .meta_i     (rd_meta),
    .inflight_i (rd_valid),
    .space_o    (space),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule
